// ===== rtl/lcsu_pkg.sv =====
// Shared types and constants for the longest common substring unit.
package lcsu_pkg;

   localparam int MAX_LEN_DEFAULT = 256;

   typedef struct packed {
      logic       string_select;
      logic [7:0] char_value;
      logic       end_of_string;
   } req_type;

   typedef struct packed {
      logic [7:0] start_in_first;
      logic [7:0] start_in_second;
      logic [8:0] match_length;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic scan_start;
      logic publish;
   } cmd_type;

   typedef struct packed {
      logic busy;
   } status_type;

endpackage

// ===== rtl/lcsu_ctrl.sv =====
// Controller: sequences loading, the diagonal scan and result hand-off.
module lcsu_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  lcsu_pkg::req_type    req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output lcsu_pkg::cmd_type    cmd,
   input  lcsu_pkg::status_type status
);
   import lcsu_pkg::*;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_START,
      ST_SCAN
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;

   assign req_ready = (state_ff == ST_LOAD);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd            = '0;
      cmd.load       = accept;
      cmd.scan_start = (state_ff == ST_START);
      cmd.publish    = (state_ff == ST_SCAN) && !status.busy &&
                       (!rsp_valid_ff || rsp_ready);
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_LOAD: begin
            // end of the second string kicks off the search
            if (accept && req_data.string_select && req_data.end_of_string) begin
               state_in = ST_START;
            end
         end
         ST_START: begin
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (cmd.publish) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== rtl/lcsu_dp.sv =====
// Datapath: string stores, diagonal walker, run tracker and best-match register.
module lcsu_dp #(
   parameter int MAX_LEN = lcsu_pkg::MAX_LEN_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  lcsu_pkg::req_type    req_data,
   input  lcsu_pkg::cmd_type    cmd,
   output lcsu_pkg::status_type status,
   output lcsu_pkg::rsp_type    rsp_data
);
   import lcsu_pkg::*;

   localparam int AW = $clog2(MAX_LEN);
   localparam int CW = $clog2(MAX_LEN + 1);
   localparam logic [CW-1:0] MAX_CNT = CW'(MAX_LEN);
   localparam logic [CW-1:0] ONE     = CW'(1);

   logic [7:0] mem_a [MAX_LEN];
   logic [7:0] mem_b [MAX_LEN];

   // load side
   logic [CW-1:0] count_a_ff, count_a_in;
   logic [CW-1:0] count_b_ff, count_b_in;
   logic          first_done_ff, first_done_in;
   logic [CW-1:0] wr_a_idx;
   logic          wr_a_en, wr_b_en;

   // walker stage
   logic          s0_valid_ff, s0_valid_in;
   logic [CW-1:0] s0_i_ff, s0_i_in, s0_j_ff, s0_j_in;
   logic          s0_first_ff, s0_first_in;
   logic [CW-1:0] st_i_ff, st_i_in, st_j_ff, st_j_in;
   logic          diag_more;

   // compare stage
   logic [7:0]    a_rd_ff, b_rd_ff;
   logic          s1_valid_ff;
   logic [CW-1:0] s1_i_ff, s1_j_ff;
   logic          s1_first_ff, s1_last_ff;
   logic [CW-1:0] run_len_ff, run_len_in;
   logic [CW-1:0] run_i_ff, run_i_in, run_j_ff, run_j_in;
   logic [CW-1:0] prev_len;
   logic          chars_eq;

   // candidate and best
   logic          cand_valid_ff, cand_valid_in;
   logic [CW-1:0] cand_len_ff, cand_len_in;
   logic [CW-1:0] cand_i_ff, cand_i_in, cand_j_ff, cand_j_in;
   logic [CW-1:0] best_len_ff, best_i_ff, best_j_ff;
   logic          better;
   rsp_type       rsp_ff;

   // ---------------- loading ----------------
   always_comb begin
      wr_a_idx      = first_done_ff ? '0 : count_a_ff;
      wr_a_en       = 1'b0;
      wr_b_en       = 1'b0;
      count_a_in    = count_a_ff;
      count_b_in    = count_b_ff;
      first_done_in = first_done_ff;
      if (cmd.load) begin
         if (!req_data.string_select) begin
            // a byte after the first string ended opens a new first string
            count_a_in    = wr_a_idx;
            first_done_in = req_data.end_of_string;
            if (wr_a_idx < MAX_CNT) begin
               wr_a_en    = 1'b1;
               count_a_in = wr_a_idx + ONE;
            end
         end else if (count_b_ff < MAX_CNT) begin
            wr_b_en    = 1'b1;
            count_b_in = count_b_ff + ONE;
         end
      end
      if (cmd.publish) begin
         count_a_in    = '0;
         count_b_in    = '0;
         first_done_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_a_en) begin
         mem_a[wr_a_idx[AW-1:0]] <= req_data.char_value;
      end
      if (wr_b_en) begin
         mem_b[count_b_ff[AW-1:0]] <= req_data.char_value;
      end
      a_rd_ff <= mem_a[s0_i_ff[AW-1:0]];
      b_rd_ff <= mem_b[s0_j_ff[AW-1:0]];
   end

   // ---------------- diagonal walker ----------------
   // Diagonals start at (0,0..n2-1), then (1..n1-1,0); each runs to an edge.
   assign diag_more = ((s0_i_ff + ONE) < count_a_ff) && ((s0_j_ff + ONE) < count_b_ff);

   always_comb begin
      s0_valid_in = s0_valid_ff;
      s0_i_in     = s0_i_ff;
      s0_j_in     = s0_j_ff;
      s0_first_in = 1'b0;
      st_i_in     = st_i_ff;
      st_j_in     = st_j_ff;
      if (cmd.scan_start) begin
         s0_valid_in = (count_a_ff != '0) && (count_b_ff != '0);
         s0_i_in     = '0;
         s0_j_in     = '0;
         s0_first_in = 1'b1;
         st_i_in     = '0;
         st_j_in     = '0;
      end else if (s0_valid_ff) begin
         if (diag_more) begin
            s0_i_in = s0_i_ff + ONE;
            s0_j_in = s0_j_ff + ONE;
         end else if ((st_i_ff == '0) && ((st_j_ff + ONE) < count_b_ff)) begin
            st_j_in     = st_j_ff + ONE;
            s0_i_in     = '0;
            s0_j_in     = st_j_ff + ONE;
            s0_first_in = 1'b1;
         end else if ((st_i_ff + ONE) < count_a_ff) begin
            st_i_in     = st_i_ff + ONE;
            st_j_in     = '0;
            s0_i_in     = st_i_ff + ONE;
            s0_j_in     = '0;
            s0_first_in = 1'b1;
         end else begin
            s0_valid_in = 1'b0;
         end
      end
   end

   // ---------------- run tracking ----------------
   assign prev_len = s1_first_ff ? '0 : run_len_ff;
   assign chars_eq = (a_rd_ff == b_rd_ff);

   always_comb begin
      run_len_in    = run_len_ff;
      run_i_in      = run_i_ff;
      run_j_in      = run_j_ff;
      cand_valid_in = 1'b0;
      cand_len_in   = prev_len;
      cand_i_in     = run_i_ff;
      cand_j_in     = run_j_ff;
      if (s1_valid_ff) begin
         if (chars_eq) begin
            run_len_in = prev_len + ONE;
            if (prev_len == '0) begin
               run_i_in = s1_i_ff;
               run_j_in = s1_j_ff;
            end
            // run reaches the edge of the diagonal: close it here
            if (s1_last_ff) begin
               cand_valid_in = 1'b1;
               cand_len_in   = prev_len + ONE;
               cand_i_in     = run_i_in;
               cand_j_in     = run_j_in;
            end
         end else begin
            run_len_in    = '0;
            cand_valid_in = (prev_len != '0);
         end
      end
   end

   // ---------------- best match ----------------
   assign better = (cand_len_ff > best_len_ff) ||
                   ((cand_len_ff == best_len_ff) &&
                    ((cand_i_ff < best_i_ff) ||
                     ((cand_i_ff == best_i_ff) && (cand_j_ff < best_j_ff))));

   always_ff @(posedge clock) begin
      s1_i_ff     <= s0_i_ff;
      s1_j_ff     <= s0_j_ff;
      s1_first_ff <= s0_first_ff;
      s1_last_ff  <= !diag_more;
      run_len_ff  <= run_len_in;
      run_i_ff    <= run_i_in;
      run_j_ff    <= run_j_in;
      cand_len_ff <= cand_len_in;
      cand_i_ff   <= cand_i_in;
      cand_j_ff   <= cand_j_in;
      s0_i_ff     <= s0_i_in;
      s0_j_ff     <= s0_j_in;
      s0_first_ff <= s0_first_in;
      st_i_ff     <= st_i_in;
      st_j_ff     <= st_j_in;
      if (cmd.scan_start) begin
         best_len_ff <= '0;
         best_i_ff   <= '0;
         best_j_ff   <= '0;
      end else if (cand_valid_ff && better) begin
         best_len_ff <= cand_len_ff;
         best_i_ff   <= cand_i_ff;
         best_j_ff   <= cand_j_ff;
      end
      if (cmd.publish) begin
         rsp_ff.start_in_first  <= 8'(best_i_ff);
         rsp_ff.start_in_second <= 8'(best_j_ff);
         rsp_ff.match_length    <= 9'(best_len_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_a_ff    <= '0;
         count_b_ff    <= '0;
         first_done_ff <= 1'b0;
         s0_valid_ff   <= 1'b0;
         s1_valid_ff   <= 1'b0;
         cand_valid_ff <= 1'b0;
      end else begin
         count_a_ff    <= count_a_in;
         count_b_ff    <= count_b_in;
         first_done_ff <= first_done_in;
         s0_valid_ff   <= s0_valid_in;
         s1_valid_ff   <= s0_valid_ff;
         cand_valid_ff <= cand_valid_in;
      end
   end

   assign status.busy = s0_valid_ff || s1_valid_ff || cand_valid_ff;
   assign rsp_data    = rsp_ff;

endmodule

// ===== rtl/longest_common_substring_unit.sv =====
// Loading: one character item per cycle while req_ready is high.
// Search: the item ending the second string starts the search, which walks the diagonals
// of the two strings; the diagonal walk visits one cell per cycle.
// req_ready is low from that item until the result enters the output register.
// The output register frees the input side while the result waits on rsp_ready.
// Synchronous reset empties both strings and drops any pending result.
module longest_common_substring_unit #(
   parameter int MAX_LEN = lcsu_pkg::MAX_LEN_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  lcsu_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output lcsu_pkg::rsp_type rsp_data
);
   import lcsu_pkg::*;

   cmd_type    cmd;
   status_type status;

   lcsu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   lcsu_dp #(
      .MAX_LEN (MAX_LEN)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .status   (status),
      .rsp_data (rsp_data)
   );

endmodule

// ===== rtl/lcsu_checker.sv =====
// Port-level checks for the longest common substring unit, bound to the top level.
module lcsu_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input lcsu_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input lcsu_pkg::rsp_type rsp_data
);
   import lcsu_pkg::*;

   logic trigger;
   assign trigger = req_valid && req_ready && req_data.string_select &&
                    req_data.end_of_string;

   // a pending result holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result item dropped or changed while stalled");

   // end of the second string stops intake for the search
   a_search_blocks: assert property (@(posedge clock) disable iff (reset)
      trigger |=> !req_ready)
      else $error("input accepted right after search trigger");

   // a result appears only at the end of a search
   a_rsp_after_search: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result item without a search");

   // the start and scan states lie between the trigger and the result
   a_min_latency: assert property (@(posedge clock) disable iff (reset)
      trigger |=> !$rose(rsp_valid))
      else $error("result item one cycle after trigger");

endmodule

bind longest_common_substring_unit lcsu_checker u_lcsu_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// ===== verif/longest_common_substring_unit_tb.sv =====
// Testbench for the longest common substring unit: string pairs checked against a software search.
`timescale 1ns / 1ps

module longest_common_substring_unit_tb;
   import lcsu_pkg::*;

   localparam int TEXT_DEPTH   = MAX_LEN_DEFAULT;
   localparam int STALL_LIMIT  = 300000;
   localparam int LONG_HOLD    = 400;
   localparam int RANDOM_ITEMS = 750;
   localparam int REPORT_LIMIT = 10;

   typedef logic [7:0] text_type [$];

   class match_scoreboard;
      logic [7:0]  first_str  [TEXT_DEPTH];
      logic [7:0]  second_str [TEXT_DEPTH];
      int unsigned first_len = 0;
      int unsigned second_len = 0;
      bit          first_ended = 1'b0;
      rsp_type     pending_matches [$];
      int          match_errors = 0;

      // Exhaustive search; ties keep the earliest start in the first string, then the second.
      function rsp_type find_longest_run();
         rsp_type     best;
         int unsigned run;
         best = '0;
         for (int unsigned i = 0; i < first_len; i++) begin
            for (int unsigned j = 0; j < second_len; j++) begin
               run = 0;
               while (i + run < first_len && j + run < second_len &&
                      first_str[i + run] == second_str[j + run])
                  run++;
               if (run > best.match_length) begin
                  best.match_length    = 9'(run);
                  best.start_in_first  = 8'(i);
                  best.start_in_second = 8'(j);
               end
            end
         end
         return best;
      endfunction

      function void note_item(req_type item);
         if (!item.string_select) begin
            // a byte after the first string ended begins a new first string
            if (first_ended) begin
               first_len   = 0;
               first_ended = 1'b0;
            end
            if (first_len < TEXT_DEPTH) begin
               first_str[first_len] = item.char_value;
               first_len++;
            end
            if (item.end_of_string) begin
               first_ended = 1'b1;
            end
         end else begin
            if (second_len < TEXT_DEPTH) begin
               second_str[second_len] = item.char_value;
               second_len++;
            end
            if (item.end_of_string) begin
               pending_matches.push_back(find_longest_run());
               first_len   = 0;
               second_len  = 0;
               first_ended = 1'b0;
            end
         end
      endfunction

      function void report(string what, rsp_type want, rsp_type got);
         match_errors++;
         if (match_errors <= REPORT_LIMIT) begin
            $display("%0t: %s: expected first %0d second %0d length %0d",
                     $realtime, what, want.start_in_first, want.start_in_second,
                     want.match_length,
                     ", got first %0d second %0d length %0d",
                     got.start_in_first, got.start_in_second, got.match_length);
         end
      endfunction

      function void check_match(rsp_type got);
         rsp_type want;
         if (pending_matches.size() == 0) begin
            report("unexpected result", '0, got);
            return;
         end
         want = pending_matches.pop_front();
         if (got.start_in_first !== want.start_in_first ||
             got.start_in_second !== want.start_in_second ||
             got.match_length !== want.match_length) begin
            report("result mismatch", want, got);
         end
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   match_scoreboard sb = new();
   int idle_pct = 0;
   int items_sent = 0;
   bit hold_req = 1'b0;

   longest_common_substring_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 80) return $urandom_range(1, 3);
      if (roll < 95) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic text_type make_alphabet(int count);
      text_type chars;
      repeat (count) chars.push_back(8'($urandom_range(0, 255)));
      return chars;
   endfunction

   function automatic text_type random_text(int len, text_type alphabet);
      text_type text;
      repeat (len) text.push_back(alphabet[$urandom_range(0, alphabet.size() - 1)]);
      return text;
   endfunction

   // Drive one item from a falling edge, hold it until accepted, then maybe idle.
   task automatic offer(bit sel, logic [7:0] ch, bit last);
      req_type item;
      item.string_select = sel;
      item.char_value    = ch;
      item.end_of_string = last;
      req_data  <= item;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      sb.note_item(req_data);
      items_sent++;
      @(negedge clock);
      if ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         repeat (pick_gap()) @(negedge clock);
      end
   endtask

   task automatic send_text(bit sel, text_type text, bit ends);
      foreach (text[k]) offer(sel, text[k], ends && k == text.size() - 1);
   endtask

   initial begin : receiver
      int stall_left;
      stall_left = 0;
      wait (!reset);
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (hold_req) begin
            // long hold-off so the block backs up into its input
            hold_req   = 1'b0;
            stall_left = LONG_HOLD - 1;
            rsp_ready  <= 1'b0;
         end else if ($urandom_range(0, 99) < idle_pct) begin
            stall_left = pick_gap() - 1;
            rsp_ready  <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         sb.check_match(rsp_data);
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
         else quiet++;
      end
      $display("simulation failed");
      $finish;
   end

   initial begin : stimulus
      text_type alphabet;
      text_type first;
      text_type second;
      int       kind;
      int       slice;
      int       from;
      int       at;
      bit       big_done;
      bit       hold_done;
      big_done  = 1'b0;
      hold_done = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      idle_pct = 20;

      // run of two bytes using both ends of the byte range
      offer(1'b0, 8'h00, 1'b0);
      offer(1'b0, 8'hFF, 1'b0);
      offer(1'b0, 8'h41, 1'b1);
      offer(1'b1, 8'hFF, 1'b0);
      offer(1'b1, 8'h41, 1'b0);
      offer(1'b1, 8'h00, 1'b1);
      // empty first string
      offer(1'b1, 8'h10, 1'b1);
      // nothing in common
      offer(1'b0, 8'h01, 1'b0);
      offer(1'b0, 8'h02, 1'b1);
      offer(1'b1, 8'h03, 1'b1);
      // tie between two equal runs: the earlier start in the first string wins
      offer(1'b0, 8'h07, 1'b0);
      offer(1'b0, 8'h08, 1'b0);
      offer(1'b0, 8'h01, 1'b0);
      offer(1'b0, 8'h07, 1'b0);
      offer(1'b0, 8'h08, 1'b1);
      offer(1'b1, 8'h02, 1'b0);
      offer(1'b1, 8'h07, 1'b0);
      offer(1'b1, 8'h08, 1'b1);
      // second bytes before the first ends, a restarted first string, search on an open one
      offer(1'b0, 8'h33, 1'b1);
      offer(1'b1, 8'h44, 1'b0);
      offer(1'b0, 8'h44, 1'b0);
      offer(1'b1, 8'h55, 1'b1);

      items_sent = 0;
      while (items_sent < RANDOM_ITEMS) begin
         idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
         if (!hold_done && items_sent >= 200) begin
            hold_req  = 1'b1;
            hold_done = 1'b1;
         end
         kind = $urandom_range(0, 99);
         if (!big_done && items_sent >= 400) begin
            // both strings overflow and end on dropped bytes; full-length match
            alphabet = make_alphabet(256);
            first    = random_text(TEXT_DEPTH + 2, alphabet);
            send_text(1'b0, first, 1'b1);
            send_text(1'b1, first, 1'b1);
            big_done = 1'b1;
         end else if (kind >= 90) begin
            repeat ($urandom_range(1, 8)) begin
               offer(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                     $urandom_range(0, 9) < 3);
            end
         end else if (kind >= 84) begin
            alphabet = make_alphabet(2);
            send_text(1'b1, random_text($urandom_range(1, 4), alphabet), 1'b1);
         end else begin
            alphabet = make_alphabet(($urandom_range(0, 9) < 8) ? $urandom_range(1, 3)
                                                                 : $urandom_range(4, 16));
            first  = random_text($urandom_range(1, 10), alphabet);
            second = random_text($urandom_range(1, 10), alphabet);
            if ($urandom_range(0, 1) == 1) begin
               // plant a slice of the first string into the second
               slice = $urandom_range(1, (first.size() < second.size()) ? first.size()
                                                                         : second.size());
               from  = $urandom_range(0, first.size() - slice);
               at    = $urandom_range(0, second.size() - slice);
               for (int k = 0; k < slice; k++) second[at + k] = first[from + k];
            end
            if ($urandom_range(0, 9) == 0) begin
               send_text(1'b0, random_text($urandom_range(1, 4), alphabet), 1'b1);
            end
            if ($urandom_range(0, 4) == 0) begin
               // most of the second string goes in before the first ends
               for (int k = 0; k < second.size() - 1; k++) offer(1'b1, second[k], 1'b0);
               send_text(1'b0, first, 1'b1);
               offer(1'b1, second[second.size() - 1], 1'b1);
            end else begin
               send_text(1'b0, first, 1'b1);
               send_text(1'b1, second, 1'b1);
            end
         end
      end

      idle_pct = 0;
      req_valid <= 1'b0;
      while (sb.pending_matches.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.match_errors == 0 && sb.pending_matches.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ===== longest_common_substring_unit.f =====
rtl/lcsu_pkg.sv
rtl/lcsu_ctrl.sv
rtl/lcsu_dp.sv
rtl/longest_common_substring_unit.sv
rtl/lcsu_checker.sv
verif/longest_common_substring_unit_tb.sv
